>>> rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types of the modular exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int WIDTH_DEFAULT = 32;
   localparam int FIELD_W       = 32;

   localparam logic CSR_EXPONENT = 1'b0;
   localparam logic CSR_MODULUS  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL_START,
      ST_MUL_RUN,
      ST_SQR_START,
      ST_SQR_RUN,
      ST_DONE
   } state_type;

endpackage

>>> rtl/mexp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_cell
// One cell of the multiplier chain: holds one accumulator step.
// Doubles the incoming residue mod m and adds the addend if its bit is set.
// ----------------------------------------------------------------------------
module mexp_cell #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] acc_i,
   input  logic [WIDTH-1:0] addend,
   input  logic [WIDTH-1:0] modulus,
   input  logic             bit_i,
   output logic [WIDTH-1:0] acc_ff
);

   logic [WIDTH-1:0] acc_in;
   logic [WIDTH:0]   dbl;
   logic [WIDTH-1:0] dbl_r;
   logic [WIDTH:0]   sum;

   always_comb begin
      dbl   = {acc_i, 1'b0};
      dbl_r = (dbl >= {1'b0, modulus}) ? WIDTH'(dbl - {1'b0, modulus}) : dbl[WIDTH-1:0];
      sum   = {1'b0, dbl_r} + {1'b0, addend};
      if (bit_i) begin
         acc_in = (sum >= {1'b0, modulus}) ? WIDTH'(sum - {1'b0, modulus}) : sum[WIDTH-1:0];
      end else begin
         acc_in = dbl_r;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

>>> rtl/mexp_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_chain
// Modular multiplier: a row of two cells, the second fed by the first and the
// first fed back from the second, one cell active per cycle, MSB first.
// done marks when product holds the finished result.
// ----------------------------------------------------------------------------
module mexp_chain #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int STEPS = (WIDTH + 1) / 2;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int BW    = 2 * STEPS;

   logic [BW-1:0]    b_ff, b_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             phase_ff, phase_in;
   logic             done_ff, done_in;
   logic             en0, en1, bit1;
   logic [WIDTH-1:0] c0_acc, c1_acc, c1_src;

   // clear cell1 on start so cell0 begins from zero
   assign en0    = run_ff && !phase_ff;
   assign en1    = start || (run_ff && phase_ff);
   assign c1_src = start ? '0 : c0_acc;
   assign bit1   = start ? 1'b0 : b_ff[BW-2];

   mexp_cell #(.WIDTH(WIDTH)) u_cell0 (
      .clock(clock), .en(en0), .acc_i(c1_acc), .addend(a_ff), .modulus(modulus),
      .bit_i(b_ff[BW-1]), .acc_ff(c0_acc)
   );

   mexp_cell #(.WIDTH(WIDTH)) u_cell1 (
      .clock(clock), .en(en1), .acc_i(c1_src), .addend(a_ff), .modulus(modulus),
      .bit_i(bit1), .acc_ff(c1_acc)
   );

   // advance two multiplier bits after each cell1 step
   always_comb begin
      b_in     = b_ff;
      a_in     = a_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      if (start) begin
         b_in     = BW'(b);
         a_in     = a;
         cnt_in   = CNT_W'(STEPS);
         run_in   = 1'b1;
         phase_in = 1'b0;
      end else if (run_ff) begin
         phase_in = !phase_ff;
         if (phase_ff) begin
            b_in   = {b_ff[BW-3:0], 2'b00};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      b_ff   <= b_in;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = c1_acc;

endmodule

>>> rtl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// channel  ports                         transfer
// req      start, busy, req_base_value   start && !busy
// rsp      rsp_valid, rsp_power_mod      rsp_valid (one cycle)
// csr      csr_valid, csr_ready, csr_*   csr_valid && csr_ready
// One item takes (1 + WIDTH + set exponent bits) multiplications in the cell
// chain; a modulus of one or zero takes none and goes straight to the result.
// Reset is synchronous; the receiver cannot stall, a result shows one cycle.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [mexp_pkg::FIELD_W-1:0] req_base_value,
   output logic                         rsp_valid,
   output logic [mexp_pkg::FIELD_W-1:0] rsp_power_mod,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [mexp_pkg::FIELD_W-1:0] csr_data
);

   localparam int BIT_W = $clog2(WIDTH);

   mexp_pkg::state_type state_ff, state_in;
   logic [mexp_pkg::FIELD_W-1:0] exp_ff, mod_ff;
   logic [WIDTH-1:0] m, e_sh_ff, e_sh_in, sq_ff, sq_in, acc_ff, acc_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic mul_start, mul_done;
   logic [WIDTH-1:0] mul_a, mul_b, prod;
   logic small_mod;
   logic red_ff, red_in;

   assign m         = WIDTH'(mod_ff);
   assign small_mod = (m <= WIDTH'(1));
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= '0;
         mod_ff <= mexp_pkg::FIELD_W'(1);
      end else if (csr_valid) begin
         if (csr_index == mexp_pkg::CSR_EXPONENT) begin
            exp_ff <= csr_data;
         end else begin
            mod_ff <= csr_data;
         end
      end
   end

   // operands: base * 1 mod m to reduce, acc * sq to multiply, sq * sq to square
   assign mul_a = (state_ff == mexp_pkg::ST_REDUCE) ? WIDTH'(1) :
                  (state_ff == mexp_pkg::ST_MUL_START) ? acc_ff : sq_ff;
   assign mul_b = sq_ff;
   assign mul_start = (state_ff == mexp_pkg::ST_REDUCE) ||
                      (state_ff == mexp_pkg::ST_MUL_START) ||
                      (state_ff == mexp_pkg::ST_SQR_START);

   mexp_chain #(.WIDTH(WIDTH)) u_chain (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .modulus(m), .done(mul_done), .product(prod)
   );

   // reduction stage: a=1 never exceeds m only when m>1, guaranteed here
   always_comb begin
      state_in = state_ff;
      e_sh_in  = e_sh_ff;
      sq_in    = sq_ff;
      acc_in   = acc_ff;
      bit_in   = bit_ff;
      red_in   = red_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (start) begin
               sq_in   = WIDTH'(req_base_value);
               e_sh_in = WIDTH'(exp_ff);
               acc_in  = WIDTH'(1);
               bit_in  = '0;
               red_in  = 1'b1;
               state_in = small_mod ? mexp_pkg::ST_DONE : mexp_pkg::ST_REDUCE;
               if (small_mod) acc_in = '0;
            end
         end
         mexp_pkg::ST_REDUCE:    state_in = mexp_pkg::ST_SQR_RUN;
         mexp_pkg::ST_MUL_START: state_in = mexp_pkg::ST_MUL_RUN;
         mexp_pkg::ST_MUL_RUN: begin
            if (mul_done) begin
               acc_in   = prod;
               state_in = mexp_pkg::ST_SQR_START;
            end
         end
         mexp_pkg::ST_SQR_START: state_in = mexp_pkg::ST_SQR_RUN;
         mexp_pkg::ST_SQR_RUN: begin
            if (mul_done) begin
               sq_in = prod;
               if (red_ff) begin
                  red_in   = 1'b0;
                  state_in = e_sh_ff[0] ? mexp_pkg::ST_MUL_START : mexp_pkg::ST_SQR_START;
               end else if (bit_ff == BIT_W'(WIDTH - 1)) begin
                  state_in = mexp_pkg::ST_DONE;
               end else begin
                  bit_in   = bit_ff + 1'b1;
                  e_sh_in  = e_sh_ff >> 1;
                  state_in = e_sh_ff[1] ? mexp_pkg::ST_MUL_START
                                        : mexp_pkg::ST_SQR_START;
               end
            end
         end
         mexp_pkg::ST_DONE: state_in = mexp_pkg::ST_IDLE;
         default:           state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      e_sh_ff <= e_sh_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      bit_ff  <= bit_in;
      red_ff  <= red_in;
   end

   always_comb begin
      busy      = (state_ff != mexp_pkg::ST_IDLE);
      rsp_valid = (state_ff == mexp_pkg::ST_DONE);
   end

   assign rsp_power_mod = mexp_pkg::FIELD_W'(acc_ff);

   a_done_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held two cycles");
   a_small_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && small_mod) |-> (acc_ff == '0)) else $error("modulus one not zero");
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !small_mod) |-> (acc_ff < m)) else $error("result not reduced");

endmodule

>>> tb/sv/tb_modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_unit
// Self-checking bench for the modular exponentiation unit. A queue of bases
// feeds a clocked driver with random gaps; a clocked monitor compares each
// result strobe against a square-and-multiply predictor kept in the bench.
// Exponent and modulus are rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_unit;

   localparam int W = mexp_pkg::WIDTH_DEFAULT;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_base_value = '0;
   logic        rsp_valid;
   logic [31:0] rsp_power_mod;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = mexp_pkg::CSR_EXPONENT;
   logic [31:0] csr_data = '0;

   logic [31:0] exp_reg;
   logic [31:0] mod_reg;
   logic [31:0] pending_bases[$];
   logic [31:0] expected_powers[$];
   int          fail_count = 0;
   bit          quiet_sender = 1'b0;

   modular_exponentiation_unit #(.WIDTH(W)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_base_value(req_base_value), .rsp_valid(rsp_valid),
      .rsp_power_mod(rsp_power_mod), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] m);
      logic [64:0] acc;
      acc = '0;
      for (int i = 63; i >= 0; i--) begin
         acc = acc << 1;
         if (acc >= 65'(m)) acc = acc - 65'(m);
         if (b[i]) begin
            acc = acc + 65'(a);
            if (acc >= 65'(m)) acc = acc - 65'(m);
         end
      end
      return acc[63:0];
   endfunction

   function automatic logic [31:0] power_mod_of(logic [31:0] base);
      logic [63:0] m, e, sq, acc;
      m = 64'(mod_reg);
      e = 64'(exp_reg);
      if (m <= 64'd1) return '0;
      sq = 64'(base) % m;
      acc = 64'd1;
      for (int i = 0; i < W; i++) begin
         if (e[i]) acc = mulmod(acc, sq, m);
         sq = mulmod(sq, sq, m);
      end
      return acc[31:0];
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch: %s", what);
      fail_count++;
   endtask

   task automatic add_base(logic [31:0] value);
      pending_bases = {pending_bases, value};
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else begin
         if (start) begin
            expected_powers = {expected_powers, power_mod_of(req_base_value)};
            void'(pending_bases.pop_front());
         end
         if (pending_bases.size() > 0 &&
             (quiet_sender || $urandom_range(99) >= 35)) begin
            start <= 1'b1;
            req_base_value <= pending_bases[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_powers.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_power_mod));
         end else begin
            if (rsp_power_mod !== expected_powers[0])
               report_mismatch($sformatf("power_mod %h want %h",
                                         rsp_power_mod, expected_powers[0]));
            void'(expected_powers.pop_front());
         end
      end
   end

   task automatic write_csr(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == mexp_pkg::CSR_EXPONENT) exp_reg = value;
      else mod_reg = value;
   endtask

   task automatic drain();
      while (pending_bases.size() != 0 || start || expected_powers.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(logic [31:0] e, logic [31:0] m, int count);
      write_csr(mexp_pkg::CSR_EXPONENT, e);
      write_csr(mexp_pkg::CSR_MODULUS, m);
      for (int i = 0; i < count; i++)
         add_base(i % 4 == 0 ? 32'($urandom_range(255)) : $urandom);
      drain();
   endtask

   initial begin
      exp_reg = '0;
      mod_reg = 32'd1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // modulus one at reset values
      add_base(32'd0);
      add_base(32'hFFFF_FFFF);
      drain();
      write_csr(mexp_pkg::CSR_MODULUS, 32'hFFFF_FFFF);
      write_csr(mexp_pkg::CSR_EXPONENT, 32'd0);
      add_base(32'd0);
      add_base(32'hFFFF_FFFF);
      add_base(32'd12345);
      drain();
      write_csr(mexp_pkg::CSR_EXPONENT, 32'hFFFF_FFFF);
      add_base(32'd0);
      add_base(32'd1);
      add_base(32'd2);
      add_base(32'hFFFF_FFFE);
      add_base(32'hFFFF_FFFF);
      add_base(32'h8000_0000);
      drain();
      write_csr(mexp_pkg::CSR_EXPONENT, 32'd65537);
      write_csr(mexp_pkg::CSR_MODULUS, 32'd3233);
      add_base(32'd65);
      add_base(32'd3233);
      add_base(32'h5555_AAAA);
      drain();
      write_csr(mexp_pkg::CSR_MODULUS, 32'd2);
      add_base(32'd7);
      add_base(32'd8);
      drain();
      quiet_sender = 1'b1;
      run_phase(32'd3, 32'hFFFF_FFFB, 30);
      quiet_sender = 1'b0;
      run_phase($urandom, $urandom | 32'h8000_0000, 40);
      run_phase($urandom, 32'd1, 10);
      run_phase(32'd0, $urandom_range(2, 1000), 10);
      for (int p = 0; p < 6; p++)
         run_phase($urandom, $urandom_range(2, 32'hFFFF_FFFF), 30);
      if (fail_count == 0) begin
         $display("tb_modular_exponentiation_unit OK");
      end else begin
         $display("tb_modular_exponentiation_unit NOT OK");
      end
      $finish;
   end

   initial begin
      #(64'd100_000_000);
      $display("tb_modular_exponentiation_unit NOT OK");
      $finish;
   end

endmodule

>>> sim.f
rtl/mexp_pkg.sv
rtl/mexp_cell.sv
rtl/mexp_chain.sv
rtl/modular_exponentiation_unit.sv
tb/sv/tb_modular_exponentiation_unit.sv
